@@ design/waveguide_string_synth_top_assert.svh @@
// Assertion macros for the waveguide string synth.
// Expects clk_i and rst_ni in the scope where the macros are used.
`ifndef WAVEGUIDE_STRING_SYNTH_TOP_ASSERT_SVH
`define WAVEGUIDE_STRING_SYNTH_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WSS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/wss_pkg.sv @@
// Shared constants, types and the Q2.14 shift-and-saturate helper
// for the waveguide string synth. No dependencies.
`timescale 1ns / 1ps

package wss_pkg;

  // delay line length, range 4..32
  localparam int LINE_LENGTH = 20;
  localparam int TAG_W       = $clog2(LINE_LENGTH);
  localparam int LOAD_IDX_W  = 5;
  localparam int CMP_W       = (TAG_W > LOAD_IDX_W) ? TAG_W : LOAD_IDX_W;
  localparam int MID_CELL    = LINE_LENGTH / 2;

  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FAR_GAIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_GAIN  = 2'd2;

  // input item kinds and line codes
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_TICK  = 1'b1;
  localparam logic LINE_LEFT  = 1'b0;
  localparam logic LINE_RIGHT = 1'b1;

  localparam logic signed [SAMPLE_W-1:0] NEAR_GAIN_RST = -16'sd14746;
  localparam logic signed [SAMPLE_W-1:0] FAR_GAIN_RST  = -16'sd1622;
  localparam logic [GAIN_W-1:0]          OUT_GAIN_RST  = 15'd8000;

  typedef logic [TAG_W-1:0]           tag_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // one cell of the row: an entry of each rail plus its physical index
  typedef struct packed {
    sample_t lval;
    tag_t    ltag;
    sample_t rval;
    tag_t    rtag;
    logic    pend;   // entry waits for the reflection result
  } cell_t;

  typedef struct packed {
    logic tail;
    tag_t ltag;
    tag_t rtag;
  } cell_init_t;

  typedef struct packed {
    logic             tick;
    logic             load_left;
    logic             load_right;
    logic [CMP_W-1:0] load_idx;
    sample_t          load_value;
    sample_t          fin_left;
    sample_t          fin_right;
  } cell_ctl_t;

  // arithmetic shift right by 14, then clamp to 16-bit signed
  function automatic sample_t shift_sat(input logic signed [32:0] v);
    logic signed [18:0] q;
    begin
      q = $signed(v[32:14]);
      if (q > 19'sd32767) begin
        shift_sat = 16'sh7FFF;
      end else if (q < -19'sd32768) begin
        shift_sat = 16'sh8000;
      end else begin
        shift_sat = q[15:0];
      end
    end
  endfunction

endpackage

@@ design/wss_cell.sv @@
// One cell of the delay-line row: left and right entries with tags.
// Depends on wss_pkg.
`timescale 1ns / 1ps

module wss_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wss_pkg::cell_init_t init_i,
  input  wss_pkg::cell_ctl_t  ctl_i,
  input  wss_pkg::cell_t      nbr_i,
  output wss_pkg::cell_t      cell_o
);
  import wss_pkg::*;

  cell_t cell_q, cell_d;
  logic  hit_left, hit_right;

  always_comb begin
    hit_left  = ctl_i.load_left  && (CMP_W'(cell_q.ltag) == ctl_i.load_idx);
    hit_right = ctl_i.load_right && (CMP_W'(cell_q.rtag) == ctl_i.load_idx);
    cell_d      = cell_q;
    cell_d.pend = 1'b0;
    if (ctl_i.tick) begin
      // shift toward the head; a pending neighbor hands over its fresh result
      cell_d.ltag = nbr_i.ltag;
      cell_d.rtag = nbr_i.rtag;
      cell_d.lval = nbr_i.pend ? ctl_i.fin_left  : nbr_i.lval;
      cell_d.rval = nbr_i.pend ? ctl_i.fin_right : nbr_i.rval;
      cell_d.pend = init_i.tail;
    end else begin
      if (cell_q.pend) begin
        cell_d.lval = ctl_i.fin_left;
        cell_d.rval = ctl_i.fin_right;
      end
      // a later load wins over the reflection write
      if (hit_left) begin
        cell_d.lval = ctl_i.load_value;
      end
      if (hit_right) begin
        cell_d.rval = ctl_i.load_value;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q.lval <= '0;
      cell_q.rval <= '0;
      cell_q.ltag <= init_i.ltag;
      cell_q.rtag <= init_i.rtag;
      cell_q.pend <= 1'b0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

@@ design/wss_reflect.sv @@
// Two-tap reflection filters for both rails: products registered,
// then sum, round and saturate. Depends on wss_pkg.
`timescale 1ns / 1ps

module wss_reflect (
  input  logic             clk_i,
  input  logic             tick_i,
  input  wss_pkg::sample_t near_gain_i,
  input  wss_pkg::sample_t far_gain_i,
  input  wss_pkg::sample_t left_cur_i,
  input  wss_pkg::sample_t left_nbr_i,
  input  wss_pkg::sample_t right_cur_i,
  input  wss_pkg::sample_t right_nbr_i,
  output wss_pkg::sample_t to_left_o,
  output wss_pkg::sample_t to_right_o
);
  import wss_pkg::*;

  logic signed [31:0] p_ln_q, p_lf_q, p_rn_q, p_rf_q;
  logic signed [32:0] sum_l, sum_r;

  always_ff @(posedge clk_i) begin
    if (tick_i) begin
      p_ln_q <= near_gain_i * left_cur_i;
      p_lf_q <= far_gain_i  * left_nbr_i;
      p_rn_q <= near_gain_i * right_cur_i;
      p_rf_q <= far_gain_i  * right_nbr_i;
    end
  end

  // round half up: add 2^13 before the floor shift
  assign sum_l = {p_ln_q[31], p_ln_q} + {p_lf_q[31], p_lf_q} + 33'sd8192;
  assign sum_r = {p_rn_q[31], p_rn_q} + {p_rf_q[31], p_rf_q} + 33'sd8192;

  // each rail's reflection lands in the opposite rail
  assign to_right_o = shift_sat(sum_l);
  assign to_left_o  = shift_sat(sum_r);

endmodule

@@ design/waveguide_string_synth_top.sv @@
// Waveguide string synth: two-rail plucked string, Q2.14 samples.
// Input channel (in_valid_i / in_stall_o): a load item writes one raw entry of
// the left or right line at a physical index; a tick item produces one sample.
// Output channel (out_valid_o / out_stall_i): one sample per tick, none per load.
// Config (cfg_valid_i / cfg_ready_o): near tap, far tap, output gain; ready is
// always high. The user writes only while the block is idle; the block itself does not enforce it.
// Throughput: one item per cycle while in_stall_o is low, loads and ticks in
// any mix. A tick's sample is registered. The two reflections finish in the
// cycle after the tick (product register) and land in the tail cell then.
// The lines are a row of cells that shift one place per tick; each cell carries
// its physical index, so a load finds its entry by tag compare.
// Reset: all entries zero, positions zero, gains at their defaults.
// Stall: an output register plus one skid entry hold results; in_stall_o rises
// only once the skid entry is occupied, and drops once it drains.
// Depends on wss_pkg, wss_cell, wss_reflect and the assertion header.
`timescale 1ns / 1ps
`include "waveguide_string_synth_top_assert.svh"

module waveguide_string_synth_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input items
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                kind_i,
  input  logic                                line_select_i,
  input  logic [wss_pkg::LOAD_IDX_W-1:0]      load_index_i,
  input  logic signed [wss_pkg::SAMPLE_W-1:0] load_value_i,
  // results
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [wss_pkg::SAMPLE_W-1:0] sample_o,
  // configuration writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [wss_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [wss_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import wss_pkg::*;

  // ---------------- configuration registers ----------------
  sample_t           near_gain_q, far_gain_q;
  logic [GAIN_W-1:0] out_gain_q;
  logic              cfg_xfer;

  assign cfg_ready_o = 1'b1;
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_gain_q <= NEAR_GAIN_RST;
      far_gain_q  <= FAR_GAIN_RST;
      out_gain_q  <= OUT_GAIN_RST;
    end else if (cfg_xfer) begin
      unique case (cfg_index_i)
        REG_NEAR_GAIN: near_gain_q <= $signed(cfg_data_i);
        REG_FAR_GAIN:  far_gain_q  <= $signed(cfg_data_i);
        REG_OUT_GAIN:  out_gain_q  <= cfg_data_i[GAIN_W-1:0];
        default: ;     // unknown index, dropped
      endcase
    end
  end

  // ---------------- input transfer ----------------
  logic in_xfer, tick, load;

  assign in_xfer = in_valid_i && !in_stall_o;
  assign tick    = in_xfer && (kind_i == KIND_TICK);
  assign load    = in_xfer && (kind_i == KIND_LOAD);

  // ---------------- cell row ----------------
  // Cell i holds left_line[(l+i)%N] and right_line[(r-i)%N]; cell 0 is the
  // current entry of both rails, cell 1 the neighbor tap, MID_CELL the
  // output tap. A tick shifts everything one cell toward the head and the
  // old head tag moves to the tail, which then waits for the reflection.
  cell_t              cells [LINE_LENGTH];
  cell_t              nbrs  [LINE_LENGTH];
  logic [LINE_LENGTH-1:0] pend_vec;
  cell_ctl_t          ctl;
  sample_t            fin_left, fin_right;

  assign ctl.tick       = tick;
  assign ctl.load_left  = load && (line_select_i == LINE_LEFT);
  assign ctl.load_right = load && (line_select_i == LINE_RIGHT);
  assign ctl.load_idx   = CMP_W'(load_index_i);
  assign ctl.load_value = load_value_i;
  assign ctl.fin_left   = fin_left;
  assign ctl.fin_right  = fin_right;

  for (genvar i = 0; i < LINE_LENGTH; i++) begin : g_cell
    cell_init_t init;

    assign init.tail = (i == LINE_LENGTH - 1);
    assign init.ltag = TAG_W'(i);
    assign init.rtag = TAG_W'((LINE_LENGTH - i) % LINE_LENGTH);

    if (i == LINE_LENGTH - 1) begin : g_tail
      assign nbrs[i] = cells[0];
    end else begin : g_body
      assign nbrs[i] = cells[i+1];
    end

    assign pend_vec[i] = cells[i].pend;

    wss_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .init_i (init),
      .ctl_i  (ctl),
      .nbr_i  (nbrs[i]),
      .cell_o (cells[i])
    );
  end

  // ---------------- reflections ----------------
  wss_reflect u_reflect (
    .clk_i       (clk_i),
    .tick_i      (tick),
    .near_gain_i (near_gain_q),
    .far_gain_i  (far_gain_q),
    .left_cur_i  (cells[0].lval),
    .left_nbr_i  (cells[1].lval),
    .right_cur_i (cells[0].rval),
    .right_nbr_i (cells[1].rval),
    .to_left_o   (fin_left),
    .to_right_o  (fin_right)
  );

  // ---------------- output sample ----------------
  // gain * midpoint / 2^14, truncated toward zero, saturated
  logic signed [31:0] mid_prod;
  logic signed [32:0] mid_adj;
  sample_t            sample_res;

  assign mid_prod   = $signed({1'b0, out_gain_q}) * cells[MID_CELL].lval;
  assign mid_adj    = {mid_prod[31], mid_prod} + (mid_prod[31] ? 33'sd16383 : 33'sd0);
  assign sample_res = shift_sat(mid_adj);

  // output register with one skid entry
  logic    out_vld_q, skid_vld_q;
  sample_t out_q, skid_q;
  logic    out_free;

  assign out_free = !out_vld_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q  <= skid_vld_q || tick;
      skid_vld_q <= 1'b0;
    end else if (tick) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_vld_q ? skid_q : sample_res;
    end else if (tick) begin
      skid_q <= sample_res;
    end
  end

  assign in_stall_o  = skid_vld_q;
  assign out_valid_o = out_vld_q;
  assign sample_o    = out_q;

  // ---------------- assertions ----------------
  `WSS_ASSERT_NOW(a_skid_behind_out, skid_vld_q, out_vld_q, "skid entry held while output empty")
  `WSS_ASSERT_NEXT(a_tick_gives_sample, tick, out_vld_q, "tick transfer produced no sample")
  `WSS_ASSERT_NEXT(a_tick_marks_tail, tick, pend_vec[LINE_LENGTH-1], "tail not waiting after tick")
  `WSS_ASSERT_NOW(a_pend_only_tail, 1'b1, pend_vec[LINE_LENGTH-2:0] == '0, "pending entry off tail")

endmodule
